### rtl/lwkf_pkg.sv
// Shared constants and types for the longest window with k flips block.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package lwkf_pkg;

  // Width of the position counter and of the reported best length.
  localparam int unsigned POS_BITS   = 20;
  localparam int unsigned BEST_BITS  = 20;
  // k register width; its full range fits the ring, so no clamp is needed.
  localparam int unsigned K_BITS     = 8;
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned SLOT_BITS  = $clog2(RING_DEPTH);
  localparam int unsigned SEEN_BITS  = SLOT_BITS + 1;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Symbol codes on the input stream.
  localparam logic SYM_A = 1'b0;
  localparam logic SYM_B = 1'b1;

  // Item held between the ring read and the scoring stage.
  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic                pos_sat;
    logic                lim_a;  // more than k a's seen: window for b is bounded
    logic                lim_b;  // more than k b's seen: window for a is bounded
    logic                byp_a;  // bound is the a just written (k is zero)
    logic                byp_b;
    logic                last;
  } lwkf_s1_t;

endpackage

`default_nettype wire

### rtl/lwkf_ring.sv
// Position ring: one write port, one read port with registered read data.
// Depends on lwkf_pkg for depth and data width.
`default_nettype none

module lwkf_ring
  import lwkf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [SLOT_BITS-1:0] waddr_i,
  input  wire logic [POS_BITS-1:0]  wdata_i,
  input  wire logic                 re_i,
  input  wire logic [SLOT_BITS-1:0] raddr_i,
  output logic      [POS_BITS-1:0]  rdata_o
);

  logic [POS_BITS-1:0] mem_q [RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read data holds while the downstream stage is stalled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/lwkf_track.sv
// Accept stage: position, ring slots and occurrence counts, ring addressing,
// and the registered item handed to the scoring stage. Depends on lwkf_pkg.
`default_nettype none

module lwkf_track
  import lwkf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 acc_i,
  input  wire logic                 symbol_i,
  input  wire logic                 last_i,
  input  wire logic [K_BITS-1:0]    k_i,
  output logic                      wr_a_o,
  output logic                      wr_b_o,
  output logic      [SLOT_BITS-1:0] waddr_a_o,
  output logic      [SLOT_BITS-1:0] waddr_b_o,
  output logic      [POS_BITS-1:0]  wdata_o,
  output logic      [SLOT_BITS-1:0] raddr_a_o,
  output logic      [SLOT_BITS-1:0] raddr_b_o,
  output lwkf_s1_t                  s1_o
);

  logic [POS_BITS-1:0]  pos_q, pos_d, pos_new;
  logic [SLOT_BITS-1:0] slot_a_q, slot_a_d, slot_a_new;
  logic [SLOT_BITS-1:0] slot_b_q, slot_b_d, slot_b_new;
  logic [SEEN_BITS-1:0] seen_a_q, seen_a_d, seen_a_new;
  logic [SEEN_BITS-1:0] seen_b_q, seen_b_d, seen_b_new;
  logic                 is_a, is_b, pos_sat, k_zero;
  lwkf_s1_t             s1_d;

  always_comb begin
    is_a    = (symbol_i == SYM_A);
    is_b    = (symbol_i == SYM_B);
    k_zero  = (k_i == '0);
    pos_sat = (pos_q == POS_MAX);
    pos_new = pos_sat ? pos_q : pos_q + POS_BITS'(1);

    slot_a_new = is_a ? slot_a_q + SLOT_BITS'(1) : slot_a_q;
    slot_b_new = is_b ? slot_b_q + SLOT_BITS'(1) : slot_b_q;
    seen_a_new = (is_a && seen_a_q < SEEN_BITS'(RING_DEPTH)) ? seen_a_q + SEEN_BITS'(1)
                                                              : seen_a_q;
    seen_b_new = (is_b && seen_b_q < SEEN_BITS'(RING_DEPTH)) ? seen_b_q + SEEN_BITS'(1)
                                                              : seen_b_q;

    wr_a_o    = acc_i && is_a;
    wr_b_o    = acc_i && is_b;
    waddr_a_o = slot_a_q;
    waddr_b_o = slot_b_q;
    wdata_o   = pos_new;

    // The (k+1)-th most recent entry sits k+1 slots behind the updated write pointer.
    raddr_a_o = slot_a_new - k_i - SLOT_BITS'(1);
    raddr_b_o = slot_b_new - k_i - SLOT_BITS'(1);

    s1_d.pos     = pos_new;
    s1_d.pos_sat = pos_sat;
    s1_d.lim_a   = seen_a_new > SEEN_BITS'(k_i);
    s1_d.lim_b   = seen_b_new > SEEN_BITS'(k_i);
    // With k zero the wanted entry is the one written on this same edge.
    s1_d.byp_a   = is_a && k_zero;
    s1_d.byp_b   = is_b && k_zero;
    s1_d.last    = last_i;

    if (last_i) begin
      pos_d    = '0;
      slot_a_d = '0;
      slot_b_d = '0;
      seen_a_d = '0;
      seen_b_d = '0;
    end else begin
      pos_d    = pos_new;
      slot_a_d = slot_a_new;
      slot_b_d = slot_b_new;
      seen_a_d = seen_a_new;
      seen_b_d = seen_b_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      slot_a_q <= '0;
      slot_b_q <= '0;
      seen_a_q <= '0;
      seen_b_q <= '0;
    end else if (acc_i) begin
      pos_q    <= pos_d;
      slot_a_q <= slot_a_d;
      slot_b_q <= slot_b_d;
      seen_a_q <= seen_a_d;
      seen_b_q <= seen_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_o <= s1_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lwkf_score.sv
// Scoring stage: window lengths for both targets, running best, overflow
// flag and the output register. Depends on lwkf_pkg.
`default_nettype none

module lwkf_score
  import lwkf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire lwkf_s1_t             s1_i,
  input  wire logic [POS_BITS-1:0]  q_a_i,
  input  wire logic [POS_BITS-1:0]  q_b_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic      [BEST_BITS-1:0] best_o,
  output logic                      too_long_o,
  output logic                      done_o
);

  logic [POS_BITS-1:0]  qa, qb, len_a, len_b, cand;
  logic [BEST_BITS-1:0] best_q, best_d;
  logic                 ovf_q, ovf_d;
  logic                 valid_q, valid_d;

  always_comb begin
    qa = s1_i.byp_a ? s1_i.pos : q_a_i;
    qb = s1_i.byp_b ? s1_i.pos : q_b_i;
    // Target a is bounded by the b ring, target b by the a ring.
    len_a = s1_i.pos;
    if (s1_i.lim_b) begin
      len_a = (s1_i.pos >= qb) ? s1_i.pos - qb : '0;
    end
    len_b = s1_i.pos;
    if (s1_i.lim_a) begin
      len_b = (s1_i.pos >= qa) ? s1_i.pos - qa : '0;
    end
    // A window never exceeds the position, which already fits the best width.
    cand   = (len_a > len_b) ? len_a : len_b;
    best_d = (BEST_BITS'(cand) > best_q) ? BEST_BITS'(cand) : best_q;
    ovf_d  = ovf_q || s1_i.pos_sat;

    valid_d = valid_q;
    if (adv_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (adv_i) begin
        best_q <= s1_i.last ? '0 : best_d;
        ovf_q  <= s1_i.last ? 1'b0 : ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      best_o     <= best_d;
      too_long_o <= ovf_d;
      done_o     <= s1_i.last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

### rtl/longest_window_k_flips.sv
// Longest run of a two-symbol string made uniform by at most k changes.
//
// Input stream: one symbol per item in s_axis_tdata bit 0 (0 for 'a',
// 1 for 'b'); s_axis_tlast marks the final symbol of a string.
// Output stream: exactly one item per input item, in order. m_axis_tdata
// carries the best window length so far, m_axis_tuser the overflow flag and
// m_axis_tlast echoes the input tlast.
// k is written through cfg_we_i / cfg_wdata_i; the user must do so only while
// the block is idle, which the block itself does not enforce. An accepted item
// passes the registered ring reads, then the window compare into the output
// register. Throughput is one item per cycle while the receiver does not stall,
// set by the single read port of each position ring and the running-best update.
// Reset clears the counters, k and the pipeline; ring contents are only read
// once written. After a tlast item all string state returns to its reset
// value. When the receiver stalls, the output register holds, the middle
// stage fills, and s_axis_tready drops only when both are occupied.
// Depends on lwkf_pkg, lwkf_ring, lwkf_track and lwkf_score.
`default_nettype none

module longest_window_k_flips
  import lwkf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [K_BITS-1:0] cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [0] symbol, [7:1] zero
  input  wire logic              s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [23:0]       m_axis_tdata,   // [19:0] best_length, [23:20] zero
  output logic                   m_axis_tuser,   // [0] too_long
  output logic                   m_axis_tlast
);

  logic [K_BITS-1:0]    k_q;
  logic                 s1_valid_q;
  logic                 acc, adv, out_ready;
  logic                 wr_a, wr_b;
  logic [SLOT_BITS-1:0] waddr_a, waddr_b, raddr_a, raddr_b;
  logic [POS_BITS-1:0]  wdata, q_a, q_b;
  logic [BEST_BITS-1:0] best;
  lwkf_s1_t             s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign adv           = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  lwkf_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .symbol_i  (s_axis_tdata[0]),
    .last_i    (s_axis_tlast),
    .k_i       (k_q),
    .wr_a_o    (wr_a),
    .wr_b_o    (wr_b),
    .waddr_a_o (waddr_a),
    .waddr_b_o (waddr_b),
    .wdata_o   (wdata),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .s1_o      (s1)
  );

  lwkf_ring u_ring_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (raddr_a),
    .rdata_o (q_a)
  );

  lwkf_ring u_ring_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (raddr_b),
    .rdata_o (q_b)
  );

  lwkf_score u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_i        (s1),
    .q_a_i       (q_a),
    .q_b_i       (q_b),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .best_o      (best),
    .too_long_o  (m_axis_tuser),
    .done_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, best};

endmodule

`default_nettype wire

### verif/lwkf_window_checker.sv
// Scoreboard for longest_window_k_flips: watches the k register, both stream
// channels, predicts every result item and compares it with what the block sends.
// Depends on lwkf_pkg only.

module lwkf_window_checker
  import lwkf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [K_BITS-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [0] symbol, [7:1] zero
  input  logic              s_axis_tlast,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [23:0]       m_axis_tdata,   // [19:0] best_length, [23:20] zero
  input  logic              m_axis_tuser,   // [0] too_long
  input  logic              m_axis_tlast,
  output int                fail_count_o,
  output int                results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic [BEST_BITS-1:0] best_length;
    logic                 too_long;
    logic                 done_res;
  } window_result_t;

  window_result_t expected_windows[$];
  window_result_t want;

  // Model copy of the block's string state.
  logic [K_BITS-1:0]    k_q;
  logic [POS_BITS-1:0]  pos_q;
  logic [POS_BITS-1:0]  a_positions[RING_DEPTH];
  logic [POS_BITS-1:0]  b_positions[RING_DEPTH];
  logic [SLOT_BITS-1:0] slot_a_q;
  logic [SLOT_BITS-1:0] slot_b_q;
  logic [SEEN_BITS-1:0] seen_a_q;
  logic [SEEN_BITS-1:0] seen_b_q;
  logic [BEST_BITS-1:0] best_q;
  logic                 overflow_q;

  logic [SLOT_BITS-1:0] bound_slot;
  logic [POS_BITS-1:0]  bound_pos;
  logic [POS_BITS-1:0]  span_a;
  logic [POS_BITS-1:0]  span_b;
  logic [POS_BITS-1:0]  span_top;

  initial begin
    fail_count_o = 0;
    results_o    = 0;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
    if (fail_count_o < PRINT_CAP) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, exp_val);
    end
    fail_count_o++;
  endtask

  task automatic clear_string();
    pos_q      = '0;
    slot_a_q   = '0;
    slot_b_q   = '0;
    seen_a_q   = '0;
    seen_b_q   = '0;
    best_q     = '0;
    overflow_q = 1'b0;
  endtask

  task automatic predict_window(input logic sym, input logic last);
    if (pos_q == POS_MAX) begin
      overflow_q = 1'b1;
    end else begin
      pos_q = pos_q + 1'b1;
    end

    if (sym == SYM_A) begin
      a_positions[slot_a_q] = pos_q;
      slot_a_q = slot_a_q + 1'b1;
      if (seen_a_q < RING_DEPTH) seen_a_q = seen_a_q + 1'b1;
    end else begin
      b_positions[slot_b_q] = pos_q;
      slot_b_q = slot_b_q + 1'b1;
      if (seen_b_q < RING_DEPTH) seen_b_q = seen_b_q + 1'b1;
    end

    // A window of a's is bounded by the (k+1)-th most recent b, and the other way round.
    span_a = pos_q;
    if (seen_b_q > k_q) begin
      bound_slot = slot_b_q - k_q - 1'b1;
      bound_pos  = b_positions[bound_slot];
      span_a     = (pos_q >= bound_pos) ? pos_q - bound_pos : '0;
    end
    span_b = pos_q;
    if (seen_a_q > k_q) begin
      bound_slot = slot_a_q - k_q - 1'b1;
      bound_pos  = a_positions[bound_slot];
      span_b     = (pos_q >= bound_pos) ? pos_q - bound_pos : '0;
    end
    span_top = (span_a > span_b) ? span_a : span_b;

    // The position never exceeds the best_length range here, so best cannot saturate.
    if (span_top > best_q) best_q = span_top;

    want.best_length = best_q;
    want.too_long    = overflow_q;
    want.done_res    = last;
    expected_windows.insert(expected_windows.size(), want);

    if (last) clear_string();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q = '0;
      clear_string();
      expected_windows.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_o <= results_o + 1;
        if (expected_windows.size() == 0) begin
          flag_mismatch("result item with nothing pending", m_axis_tdata[BEST_BITS-1:0], 0);
        end else begin
          want = expected_windows.pop_front();
          if (m_axis_tdata[BEST_BITS-1:0] !== want.best_length) begin
            flag_mismatch("best_length", m_axis_tdata[BEST_BITS-1:0], want.best_length);
          end
          if (m_axis_tuser !== want.too_long) begin
            flag_mismatch("too_long", m_axis_tuser, want.too_long);
          end
          if (m_axis_tlast !== want.done_res) begin
            flag_mismatch("done_res", m_axis_tlast, want.done_res);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_window(s_axis_tdata[0], s_axis_tlast);
      end
      if (cfg_we_i) k_q = cfg_wdata_i;
    end
  end

endmodule

### verif/tb.sv
// Top of the longest_window_k_flips testbench: clock, reset, symbol stimulus,
// receiver back-pressure and the verdict. Depends on lwkf_pkg, the block and
// lwkf_window_checker, which does all prediction and comparison.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lwkf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned PHASE_ITEMS  = 123;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned HOLD_CYCLES  = 80;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [K_BITS-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  int fail_count;
  int results_seen;
  int items_sent   = 0;
  int cycle_count  = 0;
  int send_pct     = 0;
  int recv_pct     = 0;
  int hold_left    = 0;
  logic pressure_req  = 1'b0;
  logic pressure_done = 1'b0;
  // Random strings run across phase boundaries, so k also changes mid-string.
  int string_left  = 0;
  int b_bias       = 50;

  longest_window_k_flips dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lwkf_window_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .results_o     (results_seen)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the block fill up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_pct = 0;
        recv_pct = 0;
      end
      IDLE_SENDER: begin
        send_pct = 45;
        recv_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_pct = 0;
        recv_pct = 45;
      end
      default: begin
        send_pct = 12;
        recv_pct = 12;
      end
    endcase
  endtask

  task automatic send_symbol(input logic sym, input logic last);
    if ((send_pct != 0) && ($urandom_range(99) < send_pct)) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, sym};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Every item yields one result, so the block is idle once all have come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [K_BITS-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_pattern(input string pattern, input logic end_string);
    for (int i = 0; i < pattern.len(); i++) begin
      send_symbol((pattern[i] == "b") ? SYM_B : SYM_A, end_string && (i == pattern.len() - 1));
    end
  endtask

  task automatic random_symbols(input int count);
    logic sym;
    repeat (count) begin
      if (string_left == 0) begin
        string_left = ($urandom_range(7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 60);
        case ($urandom_range(3))
          0: b_bias = 10;
          1: b_bias = 90;
          2: b_bias = 50;
          default: b_bias = $urandom_range(100);
        endcase
      end
      sym = ($urandom_range(99) < b_bias) ? SYM_B : SYM_A;
      send_symbol(sym, string_left == 1);
      string_left--;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings; k starts at its reset value of zero.
    set_idling(IDLE_NONE);
    send_pattern("a", 1'b1);
    send_pattern("b", 1'b1);
    send_pattern("abbab", 1'b1);
    write_k(8'd1);
    send_pattern("aababbb", 1'b1);
    write_k(8'd255);
    send_pattern("babaa", 1'b1);
    // k lowered in the middle of a string.
    write_k(8'd3);
    send_pattern("aab", 1'b0);
    write_k(8'd0);
    send_pattern("ba", 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_k(8'd0);
        1: write_k(8'd255);
        2: write_k(8'd1);
        3: write_k(K_BITS'($urandom_range(255)));
        default: write_k(K_BITS'($urandom_range(7)));
      endcase
      set_idling(idle_mode_e'(phase % 4));
      random_symbols(PHASE_ITEMS);
    end

    // The receiver holds off while items keep coming, so the input stalls.
    write_k(8'd2);
    set_idling(IDLE_NONE);
    pressure_req <= 1'b1;
    random_symbols(40);

    // A last short string while both sides idle now and then.
    set_idling(IDLE_BOTH);
    send_pattern("abbaa", 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/lwkf_pkg.sv
rtl/lwkf_ring.sv
rtl/lwkf_track.sv
rtl/lwkf_score.sv
rtl/longest_window_k_flips.sv
verif/lwkf_window_checker.sv
verif/tb.sv
